>>> hw/rtl/rfd_pkg.sv
// Shared constants for the refraction direction pipeline
package rfd_pkg;

	localparam int DEF_COMPONENT_WIDTH = 32;
	localparam int DEF_FRACTION_BITS   = 16;

endpackage

>>> hw/rtl/rfd_mulq.sv
// Fixed-point multiply with round half up and saturation to the component width
module rfd_mulq
	import rfd_pkg::*;
#(
	parameter int AW = DEF_COMPONENT_WIDTH,
	parameter int BW = DEF_COMPONENT_WIDTH,
	parameter int W  = DEF_COMPONENT_WIDTH,
	parameter int F  = DEF_FRACTION_BITS
) (
	input  logic signed [AW-1:0] a,
	input  logic signed [BW-1:0] b,
	output logic signed [W-1:0]  q
);

	localparam int PW = AW + BW;
	localparam int SW = PW + 1 - F;
	localparam logic signed [PW:0] HALF = (PW+1)'(1) << (F - 1);
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	logic signed [PW-1:0] prod;
	logic signed [PW:0]   rnd;
	logic        [SW-1:0] sh;
	logic                 fits;

	assign prod = a * b;
	assign rnd  = $signed({prod[PW-1], prod}) + HALF;
	assign sh   = rnd[PW:F];
	assign fits = (&sh[SW-1:W-1]) || !(|sh[SW-1:W-1]);
	assign q    = fits ? $signed(sh[W-1:0]) : (sh[SW-1] ? $signed(MINV) : $signed(MAXV));

endmodule

>>> hw/rtl/rfd_front.sv
// Front stages: dot product, eta products and the discriminant k
module rfd_front
	import rfd_pkg::*;
#(
	parameter int W = DEF_COMPONENT_WIDTH,
	parameter int F = DEF_FRACTION_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  vld_i,
	input  logic [2:0][W-1:0]     inc_i,
	input  logic [2:0][W-1:0]     nrm_i,
	input  logic [F+2:0]          eta_i,
	output logic                  vld_o,
	output logic                  tir_o,
	output logic [W+F-2:0]        rad_o,
	output logic [W-1:0]          ed_o,
	output logic [2:0][W-1:0]     ei_o,
	output logic [2:0][W-1:0]     nrm_o
);

	localparam int ETW = F + 4;
	localparam int DW  = 2 * W + 2;
	localparam int DSW = DW - F;
	localparam logic signed [DW-1:0]  HALF = DW'(1) << (F - 1);
	localparam logic signed [W+1:0]   ONE  = (W+2)'(1) << F;
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	logic signed [ETW-1:0] eta_sg;
	logic [2:0][W-1:0]     ei_c;
	logic [W-1:0]          ee_c;
	logic [W-1:0]          dd_c;
	logic [W-1:0]          ed_c;
	logic [W-1:0]          kp_c;

	// stage 1
	logic                   vld_s1;
	logic [2:0][2*W-1:0]    p_s1;
	logic [W-1:0]           ee_s1;
	logic [2:0][W-1:0]      ei_s1;
	logic [2:0][W-1:0]      nrm_s1;
	logic [ETW-1:0]         eta_s1;
	// stage 2
	logic                   vld_s2;
	logic [W-1:0]           d_s2;
	logic [W-1:0]           ee_s2;
	logic [2:0][W-1:0]      ei_s2;
	logic [2:0][W-1:0]      nrm_s2;
	logic [ETW-1:0]         eta_s2;
	// stage 3
	logic                   vld_s3;
	logic [W-1:0]           dd_s3;
	logic [W-1:0]           ed_s3;
	logic [W-1:0]           ee_s3;
	logic [2:0][W-1:0]      ei_s3;
	logic [2:0][W-1:0]      nrm_s3;
	// stage 4
	logic                   vld_s4;
	logic [W-1:0]           kp_s4;
	logic [W-1:0]           ed_s4;
	logic [2:0][W-1:0]      ei_s4;
	logic [2:0][W-1:0]      nrm_s4;
	// stage 5
	logic                   vld_s5;
	logic                   tir_s5;
	logic [W+F-2:0]         rad_s5;
	logic [W-1:0]           ed_s5;
	logic [2:0][W-1:0]      ei_s5;
	logic [2:0][W-1:0]      nrm_s5;

	logic signed [DW-1:0]   dsum;
	logic signed [DW-1:0]   drnd;
	logic [DSW-1:0]         dsh;
	logic                   dfits;
	logic [W-1:0]           d_c;
	logic signed [W+1:0]    t_c;
	logic signed [W+1:0]    k_c;
	logic [W-2:0]           ksat;

	assign eta_sg = $signed({1'b0, eta_i});

	rfd_mulq #(.AW(ETW), .BW(ETW), .W(W), .F(F)) u_ee (
		.a(eta_sg), .b(eta_sg), .q(ee_c)
	);

	for (genvar i = 0; i < 3; i++) begin : g_ei
		rfd_mulq #(.AW(ETW), .BW(W), .W(W), .F(F)) u_ei (
			.a(eta_sg), .b(inc_i[i]), .q(ei_c[i])
		);
	end

	// round and saturate the exact dot product
	assign dsum = $signed({{2{p_s1[0][2*W-1]}}, p_s1[0]})
		+ $signed({{2{p_s1[1][2*W-1]}}, p_s1[1]})
		+ $signed({{2{p_s1[2][2*W-1]}}, p_s1[2]});
	assign drnd  = dsum + HALF;
	assign dsh   = drnd[DW-1:F];
	assign dfits = (&dsh[DSW-1:W-1]) || !(|dsh[DSW-1:W-1]);
	assign d_c   = dfits ? dsh[W-1:0] : (dsh[DSW-1] ? MINV : MAXV);

	rfd_mulq #(.AW(W), .BW(W), .W(W), .F(F)) u_dd (
		.a(d_s2), .b(d_s2), .q(dd_c)
	);

	rfd_mulq #(.AW(ETW), .BW(W), .W(W), .F(F)) u_ed (
		.a(eta_s2), .b(d_s2), .q(ed_c)
	);

	assign t_c = ONE - $signed({{2{dd_s3[W-1]}}, dd_s3});

	rfd_mulq #(.AW(W), .BW(W+2), .W(W), .F(F)) u_kp (
		.a(ee_s3), .b(t_c), .q(kp_c)
	);

	assign k_c  = ONE - $signed({{2{kp_s4[W-1]}}, kp_s4});
	// clamp a non-negative k to the largest component value
	assign ksat = (k_c[W:W-1] != 2'b00) ? {(W-1){1'b1}} : k_c[W-2:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p_s1[i] <= $signed(inc_i[i]) * $signed(nrm_i[i]);
			end
			ee_s1  <= ee_c;
			ei_s1  <= ei_c;
			nrm_s1 <= nrm_i;
			eta_s1 <= eta_sg;

			d_s2   <= d_c;
			ee_s2  <= ee_s1;
			ei_s2  <= ei_s1;
			nrm_s2 <= nrm_s1;
			eta_s2 <= eta_s1;

			dd_s3  <= dd_c;
			ed_s3  <= ed_c;
			ee_s3  <= ee_s2;
			ei_s3  <= ei_s2;
			nrm_s3 <= nrm_s2;

			kp_s4  <= kp_c;
			ed_s4  <= ed_s3;
			ei_s4  <= ei_s3;
			nrm_s4 <= nrm_s3;

			tir_s5 <= k_c[W+1];
			rad_s5 <= {ksat, {F{1'b0}}};
			ed_s5  <= ed_s4;
			ei_s5  <= ei_s4;
			nrm_s5 <= nrm_s4;
		end
	end

	assign vld_o = vld_s5;
	assign tir_o = tir_s5;
	assign rad_o = rad_s5;
	assign ed_o  = ed_s5;
	assign ei_o  = ei_s5;
	assign nrm_o = nrm_s5;

endmodule

>>> hw/rtl/rfd_sqrt_cell.sv
// One cell of the square-root chain: settles one root bit per item
module rfd_sqrt_cell
	import rfd_pkg::*;
#(
	parameter int VW  = DEF_COMPONENT_WIDTH + DEF_FRACTION_BITS - 1,
	parameter int NB  = (DEF_COMPONENT_WIDTH + DEF_FRACTION_BITS) / 2,
	parameter int BIT = 0
) (
	input  logic          clk,
	input  logic          en,
	input  logic [VW-1:0] rem_i,
	input  logic [NB-1:0] root_i,
	output logic [VW-1:0] rem_q,
	output logic [NB-1:0] root_q
);

	logic [VW+1:0] remx;
	logic [VW+1:0] trial;
	logic [VW+1:0] diff;

	// trial = (2*root + 2^BIT) * 2^BIT, lower root bits are still clear
	assign remx  = {2'b00, rem_i};
	assign trial = ({{(VW+2-NB){1'b0}}, root_i} << (BIT + 1)) + ((VW+2)'(1) << (2 * BIT));
	assign diff  = remx - trial;

	always_ff @(posedge clk) begin
		if (en) begin
			if (remx >= trial) begin
				rem_q  <= diff[VW-1:0];
				root_q <= root_i | (NB'(1) << BIT);
			end else begin
				rem_q  <= rem_i;
				root_q <= root_i;
			end
		end
	end

endmodule

>>> hw/rtl/rfd_back.sv
// Back stages: scale factor, normal products and the final refracted vector
module rfd_back
	import rfd_pkg::*;
#(
	parameter int W  = DEF_COMPONENT_WIDTH,
	parameter int F  = DEF_FRACTION_BITS,
	parameter int NB = (DEF_COMPONENT_WIDTH + DEF_FRACTION_BITS) / 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_i,
	input  logic              tir_i,
	input  logic [NB-1:0]     root_i,
	input  logic [W-1:0]      ed_i,
	input  logic [2:0][W-1:0] ei_i,
	input  logic [2:0][W-1:0] nrm_i,
	output logic              vld_o,
	output logic              tir_o,
	output logic [2:0][W-1:0] r_o
);

	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	logic signed [W:0]  msum;
	logic [W-1:0]       m_c;
	logic [2:0][W-1:0]  mn_c;
	logic [2:0][W:0]    rdiff;

	logic               vld_s1, vld_s2, vld_s3;
	logic               tir_s1, tir_s2, tir_s3;
	logic [W-1:0]       m_s1;
	logic [2:0][W-1:0]  ei_s1, ei_s2;
	logic [2:0][W-1:0]  nrm_s1;
	logic [2:0][W-1:0]  mn_s2;
	logic [2:0][W-1:0]  r_s3;

	assign msum = $signed({ed_i[W-1], ed_i}) + $signed({{(W+1-NB){1'b0}}, root_i});
	assign m_c  = (msum[W] == msum[W-1]) ? msum[W-1:0] : (msum[W] ? MINV : MAXV);

	for (genvar i = 0; i < 3; i++) begin : g_mn
		rfd_mulq #(.AW(W), .BW(W), .W(W), .F(F)) u_mn (
			.a(m_s1), .b(nrm_s1[i]), .q(mn_c[i])
		);
		assign rdiff[i] = $signed({ei_s2[i][W-1], ei_s2[i]})
			- $signed({mn_s2[i][W-1], mn_s2[i]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1   <= m_c;
			tir_s1 <= tir_i;
			ei_s1  <= ei_i;
			nrm_s1 <= nrm_i;

			mn_s2  <= mn_c;
			tir_s2 <= tir_s1;
			ei_s2  <= ei_s1;

			tir_s3 <= tir_s2;
			for (int i = 0; i < 3; i++) begin
				// drop the vector on total reflection
				if (tir_s2) begin
					r_s3[i] <= '0;
				end else if (rdiff[i][W] != rdiff[i][W-1]) begin
					r_s3[i] <= rdiff[i][W] ? MINV : MAXV;
				end else begin
					r_s3[i] <= rdiff[i][W-1:0];
				end
			end
		end
	end

	assign vld_o = vld_s3;
	assign tir_o = tir_s3;
	assign r_o   = r_s3;

endmodule

>>> hw/rtl/refraction_direction_3d.sv
// Five front stages, one square-root cell per root bit, three back stages.
// Throughput: one item per cycle; the whole pipeline holds while out_stall holds a result.
// Reset clears only the valid flags; data registers carry no reset.
// Top level: Snell refraction of a 3-D direction in a chain of square-root cells
module refraction_direction_3d
	import rfd_pkg::*;
#(
	parameter int COMPONENT_WIDTH = DEF_COMPONENT_WIDTH,
	parameter int FRACTION_BITS   = DEF_FRACTION_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [COMPONENT_WIDTH-1:0] incident_x,
	input  logic [COMPONENT_WIDTH-1:0] incident_y,
	input  logic [COMPONENT_WIDTH-1:0] incident_z,
	input  logic [COMPONENT_WIDTH-1:0] normal_x,
	input  logic [COMPONENT_WIDTH-1:0] normal_y,
	input  logic [COMPONENT_WIDTH-1:0] normal_z,
	input  logic [FRACTION_BITS+2:0]   eta,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [COMPONENT_WIDTH-1:0] refracted_x,
	output logic [COMPONENT_WIDTH-1:0] refracted_y,
	output logic [COMPONENT_WIDTH-1:0] refracted_z,
	output logic                       total_reflection
);

	localparam int W   = COMPONENT_WIDTH;
	localparam int F   = FRACTION_BITS;
	localparam int VW  = W + F - 1;
	localparam int NB  = (W + F) / 2;
	localparam int SBW = 7 * W + 1;

	logic              en;
	logic              f_vld, f_tir;
	logic [VW-1:0]     f_rad;
	logic [W-1:0]      f_ed;
	logic [2:0][W-1:0] f_ei, f_nrm;

	logic [NB:0][VW-1:0]  rem;
	logic [NB:0][NB-1:0]  root;
	logic [NB:0][SBW-1:0] side_q;
	logic [NB:0]          vld_q;

	logic              b_vld, b_tir;
	logic [2:0][W-1:0] b_r;

	// hold everything while a finished result waits
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	rfd_front #(.W(W), .F(F)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (in_valid),
		.inc_i  ({incident_z, incident_y, incident_x}),
		.nrm_i  ({normal_z, normal_y, normal_x}),
		.eta_i  (eta),
		.vld_o  (f_vld),
		.tir_o  (f_tir),
		.rad_o  (f_rad),
		.ed_o   (f_ed),
		.ei_o   (f_ei),
		.nrm_o  (f_nrm)
	);

	assign rem[0]    = f_rad;
	assign root[0]   = '0;
	assign side_q[0] = {f_tir, f_ed, f_ei, f_nrm};
	assign vld_q[0]  = f_vld;

	for (genvar j = 0; j < NB; j++) begin : g_cell
		rfd_sqrt_cell #(.VW(VW), .NB(NB), .BIT(NB - 1 - j)) u_cell (
			.clk    (clk),
			.en     (en),
			.rem_i  (rem[j]),
			.root_i (root[j]),
			.rem_q  (rem[j+1]),
			.root_q (root[j+1])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[j+1] <= 1'b0;
			end else if (en) begin
				vld_q[j+1] <= vld_q[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_q[j+1] <= side_q[j];
			end
		end
	end

	rfd_back #(.W(W), .F(F), .NB(NB)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_q[NB]),
		.tir_i  (side_q[NB][SBW-1]),
		.root_i (root[NB]),
		.ed_i   (side_q[NB][SBW-2 -: W]),
		.ei_i   (side_q[NB][6*W-1 -: 3*W]),
		.nrm_i  (side_q[NB][3*W-1:0]),
		.vld_o  (b_vld),
		.tir_o  (b_tir),
		.r_o    (b_r)
	);

	assign out_valid        = b_vld;
	assign total_reflection = b_tir;
	assign refracted_x      = b_r[0];
	assign refracted_y      = b_r[1];
	assign refracted_z      = b_r[2];

endmodule
